// ===== sv/cursor_array_list_engine_top_assert.svh =====
// Assertion macros for the cursor array list engine; they sample clk and reset on rst_n.
`ifndef CURSOR_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define CALE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cale: same-cycle check failed");

`define CALE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cale: next-cycle check failed");

`else

`define CALE_ASSERT_IMP(lbl, ante, cons)

`define CALE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== sv/cale_pkg.sv =====
// Shared types and constants of the cursor array list engine.
`default_nettype none

package cale_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int FUNC_W  = 4;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int CAP_W   = 7;
  localparam int CUR_W   = 7;
  localparam int CNT_W   = 7;
  localparam int ERR_W   = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  // cursor code for an empty list (-1)
  localparam logic [CUR_W-1:0] CUR_NONE  = 7'h7F;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 4'd0,
    FN_REMOVE  = 4'd1,
    FN_REPLACE = 4'd2,
    FN_CLEAR   = 4'd3,
    FN_FIRST   = 4'd4,
    FN_LAST    = 4'd5,
    FN_NEXT    = 4'd6,
    FN_PRIOR   = 4'd7,
    FN_READ    = 4'd8,
    FN_MOVE    = 4'd9,
    FN_FIND    = 4'd10
  } func_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE   = 2'd0,
    ERR_FULL   = 2'd1,
    ERR_EMPTY  = 2'd2,
    ERR_BOUNDS = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HOLD_CAP,
    ST_SHIFT,
    ST_DRAIN,
    ST_PUT,
    ST_FIND,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic at_lim;
    logic hit;
  } step_flags_t;

endpackage

`default_nettype wire

// ===== sv/cale_if.sv =====
// Handshake channels: operation words in, status words out.
`default_nettype none

interface cale_in_if
  import cale_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface cale_out_if
  import cale_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [VALUE_W-1:0]       read_value;
  logic                     success;
  logic [ERR_W-1:0]         error_code;
  logic signed [CUR_W-1:0]  cursor_index;
  logic [CNT_W-1:0]         entry_count;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output read_value, output success, output error_code,
                  output cursor_index, output entry_count, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input read_value, input success, input error_code,
                  input cursor_index, input entry_count, input is_empty,
                  input is_full, output ready);
endinterface

`default_nettype wire

// ===== sv/cale_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module cale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cale_step.sv =====
// Shared index stepper and word comparator used by every shift and scan.
`default_nettype none

module cale_step
  import cale_pkg::*;
#(
  parameter int IW = 7,
  parameter int DW = 32
) (
  input  wire logic [IW-1:0] idx,
  input  wire logic [IW-1:0] lim,
  input  wire logic          dec,
  input  wire logic [DW-1:0] a,
  input  wire logic [DW-1:0] b,
  output logic      [IW-1:0] nxt,
  output step_flags_t        flags
);

  assign nxt          = dec ? IW'(idx - 1'b1) : IW'(idx + 1'b1);
  assign flags.at_lim = (idx == lim);
  assign flags.hit    = (a == b);

endmodule

`default_nettype wire

// ===== sv/cursor_array_list_engine_top.sv =====
// Top level of the cursor array list engine: sequencer, state and result register.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+--------------------------------------------
//  in_ch   | in  | valid/ready        | func, value, position
//  out_ch  | out | valid/ready        | read_value, success, error_code, cursor,...
//  cfg     | in  | cfg_we, no stall   | capacity (7 bits)
//
// One word at a time. Insert shifts the entries above the cursor up, then writes the new
// word; remove shifts the entries above the cursor down; move captures the cursor's word,
// shifts the entries between, then writes it; find scans on from the cursor. Every entry
// moved or compared passes through the shared stepper and uses the RAM read port.
// A full result register not taken by out_ch.ready holds the sequencer in its last state.
// The next word is taken while the previous result still waits in the output
// register. Reset is synchronous; no clearing pass, the store is never read
// beyond the fill count.
`default_nettype none

module cursor_array_list_engine_top
  import cale_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  cale_in_if.sink               in_ch,
  cale_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  `include "cursor_array_list_engine_top_assert.svh"

  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int CMW = (CW > CAP_W) ? CW : CAP_W;
  localparam int DW  = DATA_WIDTH;

  state_t state_r, state_nxt, start_st;

  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    cursor_r, cursor_nxt;
  logic [CW-1:0]    src_r, src_nxt;
  logic [CW-1:0]    lim_r, lim_nxt;
  logic [CW-1:0]    dst_r, dst_nxt;
  logic             dec_r, dec_nxt;
  logic             wpend_r, wpend_nxt;
  logic [CW-1:0]    waddr_r, waddr_nxt;
  logic [CW-1:0]    put_addr_r, put_addr_nxt;
  logic [DW-1:0]    put_data_r, put_data_nxt;
  logic             put_after_r, put_after_nxt;
  logic             shift_go_r, shift_go_nxt;
  logic [DW-1:0]    val_r, val_nxt;
  logic             ok_r, ok_nxt;
  err_t             err_r, err_nxt;
  logic             scan_on_r, scan_on_nxt;
  logic             cmp_valid_r, cmp_valid_nxt;
  logic             cmp_last_r, cmp_last_nxt;
  logic [CW-1:0]    cmp_idx_r, cmp_idx_nxt;

  logic                     out_valid_r;
  logic [VALUE_W-1:0]       out_value_r;
  logic                     out_ok_r;
  logic [ERR_W-1:0]         out_err_r;
  logic [CUR_W-1:0]         out_cur_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic                     out_empty_r;
  logic                     out_full_r;
  logic                     out_load;

  logic          ram_we, ram_re;
  logic [CW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0] step_nxt;
  step_flags_t   step_flags;

  logic          in_acc;
  func_t         fn;
  logic [DW-1:0] in_val;
  logic [CMW-1:0] cap_eff;
  logic          full_now;
  logic          empty_now;
  logic [CW-1:0] pos_w;
  logic          pos_oob;
  logic [CW-1:0] ins_cur;
  logic          find_end;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign fn        = func_t'(in_ch.func);
  assign in_val    = DW'(in_ch.value);
  assign empty_now = (count_r == '0);

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CMW'(1);
    end else if (CMW'(cap_r) > CMW'(MAX_ENTRIES)) begin
      cap_eff = CMW'(MAX_ENTRIES);
    end else begin
      cap_eff = CMW'(cap_r);
    end
  end

  assign full_now = (CMW'(count_r) >= cap_eff);
  assign pos_oob  = (CMW'(in_ch.position) >= CMW'(count_r));
  assign pos_w    = CW'(in_ch.position);
  assign ins_cur  = empty_now ? '0 : CW'(cursor_r + 1'b1);
  assign find_end = cmp_valid_r && (step_flags.hit || cmp_last_r);

  cale_step #(
    .IW (CW),
    .DW (DW)
  ) u_step (
    .idx   (src_r),
    .lim   (lim_r),
    .dec   (dec_r),
    .a     (ram_rdata),
    .b     (val_r),
    .nxt   (step_nxt),
    .flags (step_flags)
  );

  cale_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = start_st;
      ST_HOLD_CAP: state_nxt = shift_go_r ? ST_SHIFT : ST_PUT;
      ST_SHIFT:    if (step_flags.at_lim) state_nxt = ST_DRAIN;
      ST_DRAIN:    state_nxt = put_after_r ? ST_PUT : ST_FETCH;
      ST_PUT:      state_nxt = ST_FETCH;
      ST_FIND:     if (find_end) state_nxt = ST_FETCH;
      ST_FETCH:    state_nxt = ST_DONE;
      ST_DONE:     if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    start_st      = ST_FETCH;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    src_nxt       = src_r;
    lim_nxt       = lim_r;
    dst_nxt       = dst_r;
    dec_nxt       = dec_r;
    wpend_nxt     = 1'b0;
    waddr_nxt     = waddr_r;
    put_addr_nxt  = put_addr_r;
    put_data_nxt  = put_data_r;
    put_after_nxt = put_after_r;
    shift_go_nxt  = shift_go_r;
    val_nxt       = val_r;
    ok_nxt        = ok_r;
    err_nxt       = err_r;
    scan_on_nxt   = scan_on_r;
    cmp_valid_nxt = 1'b0;
    cmp_last_nxt  = cmp_last_r;
    cmp_idx_nxt   = cmp_idx_r;
    ram_we        = wpend_r;
    ram_waddr     = waddr_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = src_r;
    out_load      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ok_nxt  = 1'b0;
          err_nxt = ERR_NONE;
          val_nxt = in_val;
          unique case (fn)
            FN_INSERT: begin
              if (full_now) begin
                err_nxt = ERR_FULL;
              end else begin
                cursor_nxt    = ins_cur;
                count_nxt     = CW'(count_r + 1'b1);
                put_addr_nxt  = ins_cur;
                put_data_nxt  = in_val;
                put_after_nxt = 1'b1;
                // open a gap at the new cursor, top entry first
                if (count_r > ins_cur) begin
                  src_nxt  = CW'(count_r - 1'b1);
                  lim_nxt  = ins_cur;
                  dst_nxt  = count_r;
                  dec_nxt  = 1'b1;
                  start_st = ST_SHIFT;
                end else begin
                  start_st = ST_PUT;
                end
              end
            end
            FN_REMOVE: begin
              if (empty_now) begin
                err_nxt = ERR_EMPTY;
              end else begin
                count_nxt     = CW'(count_r - 1'b1);
                cursor_nxt    = (cursor_r == CW'(count_r - 1'b1)) ? '0 : cursor_r;
                put_after_nxt = 1'b0;
                if (CW'(cursor_r + 1'b1) < count_r) begin
                  src_nxt  = CW'(cursor_r + 1'b1);
                  lim_nxt  = CW'(count_r - 1'b1);
                  dst_nxt  = cursor_r;
                  dec_nxt  = 1'b0;
                  start_st = ST_SHIFT;
                end
              end
            end
            FN_REPLACE: begin
              if (empty_now) begin
                err_nxt = ERR_EMPTY;
              end else begin
                put_addr_nxt = cursor_r;
                put_data_nxt = in_val;
                start_st     = ST_PUT;
              end
            end
            FN_CLEAR: begin
              count_nxt = '0;
            end
            FN_FIRST: begin
              if (empty_now) err_nxt = ERR_EMPTY;
              else           cursor_nxt = '0;
            end
            FN_LAST: begin
              if (empty_now) err_nxt = ERR_EMPTY;
              else           cursor_nxt = CW'(count_r - 1'b1);
            end
            FN_NEXT: begin
              if (empty_now) begin
                err_nxt = ERR_EMPTY;
              end else if (CW'(cursor_r + 1'b1) < count_r) begin
                cursor_nxt = CW'(cursor_r + 1'b1);
                ok_nxt     = 1'b1;
              end
            end
            FN_PRIOR: begin
              if (empty_now) begin
                err_nxt = ERR_EMPTY;
              end else if (cursor_r != '0) begin
                cursor_nxt = CW'(cursor_r - 1'b1);
                ok_nxt     = 1'b1;
              end
            end
            FN_READ: begin
              if (empty_now) err_nxt = ERR_EMPTY;
            end
            FN_MOVE: begin
              if (empty_now) begin
                err_nxt = ERR_EMPTY;
              end else if (pos_oob) begin
                err_nxt = ERR_BOUNDS;
              end else begin
                // fetch the cursor's word now, park it once the gap is made
                ram_re        = 1'b1;
                ram_raddr     = cursor_r;
                cursor_nxt    = pos_w;
                put_addr_nxt  = pos_w;
                put_after_nxt = 1'b1;
                shift_go_nxt  = (pos_w != cursor_r);
                lim_nxt       = pos_w;
                dst_nxt       = cursor_r;
                dec_nxt       = (pos_w < cursor_r);
                src_nxt       = (pos_w < cursor_r) ? CW'(cursor_r - 1'b1)
                                                   : CW'(cursor_r + 1'b1);
                start_st      = ST_HOLD_CAP;
              end
            end
            FN_FIND: begin
              if (empty_now) begin
                err_nxt = ERR_EMPTY;
              end else begin
                src_nxt     = cursor_r;
                lim_nxt     = CW'(count_r - 1'b1);
                dec_nxt     = 1'b0;
                scan_on_nxt = 1'b1;
                start_st    = ST_FIND;
              end
            end
            default: ;
          endcase
        end
      end
      ST_HOLD_CAP: begin
        put_data_nxt = ram_rdata;
      end
      ST_SHIFT: begin
        // read one source a cycle, write it to its neighbour in the next cycle
        ram_re    = 1'b1;
        ram_raddr = src_r;
        wpend_nxt = 1'b1;
        waddr_nxt = dst_r;
        dst_nxt   = src_r;
        src_nxt   = step_nxt;
      end
      ST_DRAIN: ;
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = put_addr_r;
        ram_wdata = put_data_r;
      end
      ST_FIND: begin
        if (cmp_valid_r && step_flags.hit) begin
          cursor_nxt = cmp_idx_r;
          ok_nxt     = 1'b1;
        end else if (cmp_valid_r && cmp_last_r) begin
          cursor_nxt = cmp_idx_r;
        end else if (scan_on_r) begin
          ram_re        = 1'b1;
          ram_raddr     = src_r;
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = src_r;
          cmp_last_nxt  = step_flags.at_lim;
          scan_on_nxt   = !step_flags.at_lim;
          src_nxt       = step_nxt;
        end
      end
      ST_FETCH: begin
        ram_re    = !empty_now;
        ram_raddr = cursor_r;
      end
      ST_DONE: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      cursor_r    <= '0;
      wpend_r     <= 1'b0;
      scan_on_r   <= 1'b0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      wpend_r     <= wpend_nxt;
      scan_on_r   <= scan_on_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r       <= src_nxt;
    lim_r       <= lim_nxt;
    dst_r       <= dst_nxt;
    dec_r       <= dec_nxt;
    waddr_r     <= waddr_nxt;
    put_addr_r  <= put_addr_nxt;
    put_data_r  <= put_data_nxt;
    put_after_r <= put_after_nxt;
    shift_go_r  <= shift_go_nxt;
    val_r       <= val_nxt;
    ok_r        <= ok_nxt;
    err_r       <= err_nxt;
    cmp_last_r  <= cmp_last_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    if (out_load) begin
      out_value_r <= empty_now ? '0 : VALUE_W'(ram_rdata);
      out_ok_r    <= ok_r;
      out_err_r   <= err_r;
      out_cur_r   <= empty_now ? CUR_NONE : CUR_W'(cursor_r);
      out_cnt_r   <= CNT_W'(count_r);
      out_empty_r <= empty_now;
      out_full_r  <= full_now;
    end
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_value   = out_value_r;
  assign out_ch.success      = out_ok_r;
  assign out_ch.error_code   = out_err_r;
  assign out_ch.cursor_index = out_cur_r;
  assign out_ch.entry_count  = out_cnt_r;
  assign out_ch.is_empty     = out_empty_r;
  assign out_ch.is_full      = out_full_r;

  `CALE_ASSERT_NXT(a_acc_busy, in_acc, state_r != ST_IDLE)
  `CALE_ASSERT_IMP(a_cur_in_list, state_r == ST_IDLE && count_r != '0, cursor_r < count_r)
  `CALE_ASSERT_IMP(a_wr_phase, ram_we, state_r == ST_SHIFT || state_r == ST_DRAIN || state_r == ST_PUT)
  `CALE_ASSERT_NXT(a_load_shows, out_load, out_ch.valid && state_r == ST_IDLE)

endmodule

`default_nettype wire
